### src/gbb_pkg.sv
`timescale 1ns / 1ps
package gbb_pkg;
  localparam int GridSide  = 128;
  localparam int CoordW    = $clog2(GridSide);
  localparam int Cells     = GridSide * GridSide;
  localparam int AddrW     = $clog2(Cells);
  localparam int PtrW      = AddrW + 1;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 7;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActRun   = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;
  localparam logic [1:0] ActSpare = 2'd3;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StFound  = 2'd1;
  localparam logic [1:0] StNoPath = 2'd2;

  localparam logic [2:0] MarkWall   = 3'd0;
  localparam logic [2:0] MarkOpen   = 3'd1;
  localparam logic [2:0] MarkStart  = 3'd2;
  localparam logic [2:0] MarkTarget = 3'd3;
  localparam logic [2:0] MarkSSide  = 3'd4;
  localparam logic [2:0] MarkTSide  = 3'd5;
  localparam logic [2:0] MarkPath   = 3'd6;

  localparam logic [CfgIdxW-1:0] RegStartRow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartCol  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTargetRow = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTargetCol = 3'd3;
  localparam logic [CfgIdxW-1:0] RegExpand    = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [CoordW-1:0] cell_row;
    logic [CoordW-1:0] cell_col;
    logic              is_wall;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        cell_mark;
    logic [CoordW-1:0] meet_row;
    logic [CoordW-1:0] meet_col;
  } rsp_t;
endpackage

### src/gbb_req_if.sv
`timescale 1ns / 1ps
interface gbb_req_if;
  logic             valid;
  logic             ready;
  gbb_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/gbb_rsp_if.sv
`timescale 1ns / 1ps
interface gbb_rsp_if;
  logic             valid;
  logic             ready;
  gbb_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/grid_bidirectional_bfs_core.sv
`timescale 1ns / 1ps
// A wall write or unknown request gives its result in the cycle after acceptance, a cell
// read passes through S_READ_WAIT to S_OUT; the next request is taken after the result leaves.
// A run makes a clearing pass over every cell, then expands cells with the sides taking turns,
// probing four neighbours per cell, then walks back over the path cells (same seeds answer after the pass).
// Throughput: one request at a time; all state lies in single-port memories.
// Reset: synchronous; registers take their reset values, then a clearing pass opens all walls.
module grid_bidirectional_bfs_core (
  input  logic                            clk,
  input  logic                            rst,
  gbb_req_if.sink                         req,
  gbb_rsp_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [gbb_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [gbb_pkg::CfgDataW-1:0]    cfg_data
);
  localparam int CW = gbb_pkg::CoordW;
  localparam int AW = gbb_pkg::AddrW;
  localparam int PW = gbb_pkg::PtrW;
  localparam logic [CW-1:0] Last = CW'(gbb_pkg::GridSide - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WIPE, S_PROBE, S_PROBE_WAIT, S_DECIDE, S_POP, S_POP_WAIT,
    S_TRACE, S_TRACE_WAIT, S_READ_WAIT, S_OUT
  } state_t;

  state_t state;

  // memories: wall, visit (2b), parent (2b), path, two queues
  logic          wall_mem   [gbb_pkg::Cells];
  logic [1:0]    visit_mem  [gbb_pkg::Cells];
  logic [1:0]    parent_mem [gbb_pkg::Cells];
  logic          path_mem   [gbb_pkg::Cells];
  logic [AW-1:0] sq_mem     [gbb_pkg::Cells];
  logic [AW-1:0] tq_mem     [gbb_pkg::Cells];

  logic          wall_rd, path_rd;
  logic [1:0]    visit_rd, parent_rd;
  logic [AW-1:0] sq_rd, tq_rd;

  logic [CW-1:0] start_row, start_col, target_row, target_col;
  logic [4:0]    expansions_per_turn;

  logic [PW-1:0] s_head, s_tail, t_head, t_tail;
  logic [AW:0]   wipe_cnt;
  logic          init_pass;    // 1 during the clearing pass after reset
  logic          side;         // 0 start side, 1 target side
  logic [4:0]    turn_cnt;
  logic [AW-1:0] cur;
  logic [1:0]    dir;
  logic [AW-1:0] nb;
  logic          nb_ok;
  logic [AW-1:0] meet;
  logic          trace_pass;   // 0 tracing current, 1 tracing neighbour
  logic          trace_side;
  logic [AW-1:0] trace_idx;
  logic [AW-1:0] trace_nb;
  logic [AW:0]   trace_cnt;
  logic [CW-1:0] rd_row, rd_col;
  gbb_pkg::rsp_t out_q;

  logic [AW-1:0] si, ti;
  assign si = {start_row, start_col};
  assign ti = {target_row, target_col};

  function automatic logic frame(input logic [CW-1:0] r, input logic [CW-1:0] c);
    frame = (r == '0) || (c == '0) || (r == Last) || (c == Last);
  endfunction

  // neighbour of cur in direction dir
  logic [CW-1:0] cr, cc, nr, nc;
  logic          nb_in;
  always_comb begin
    cr = cur[AW-1:CW];
    cc = cur[CW-1:0];
    nr = cr;
    nc = cc;
    nb_in = 1'b1;
    unique case (dir)
      2'd0: begin nr = cr + 1'b1; nb_in = (cr != Last); end
      2'd1: begin nr = cr - 1'b1; nb_in = (cr != '0); end
      2'd2: begin nc = cc + 1'b1; nb_in = (cc != Last); end
      default: begin nc = cc - 1'b1; nb_in = (cc != '0); end
    endcase
  end

  // parent step back from trace_idx
  logic [CW-1:0] tr, tc, pr, pc;
  logic          p_in;
  always_comb begin
    tr = trace_idx[AW-1:CW];
    tc = trace_idx[CW-1:0];
    pr = tr;
    pc = tc;
    p_in = 1'b1;
    unique case (parent_rd)
      2'd0: begin pr = tr - 1'b1; p_in = (tr != '0); end
      2'd1: begin pr = tr + 1'b1; p_in = (tr != Last); end
      2'd2: begin pc = tc - 1'b1; p_in = (tc != '0); end
      default: begin pc = tc + 1'b1; p_in = (tc != Last); end
    endcase
  end

  logic [AW-1:0] trace_seed;
  assign trace_seed = trace_side ? ti : si;

  logic s_has, t_has;
  assign s_has = s_head < s_tail;
  assign t_has = t_head < t_tail;

  logic [4:0] per;
  assign per = (expansions_per_turn == '0) ? 5'd1 : expansions_per_turn;

  // memory address and write controls
  logic [AW-1:0] addr;
  logic          wall_we, visit_we, parent_we, path_we, sq_we, tq_we;
  logic          wall_wd, path_wd;
  logic [1:0]    visit_wd;
  logic [AW-1:0] sq_addr, tq_addr, q_wd;

  logic new_visit;
  assign new_visit = nb_ok && !wall_rd && (visit_rd == 2'd0);
  logic hit_other;
  assign hit_other = nb_ok && !wall_rd && (visit_rd == (side ? 2'd1 : 2'd2));

  always_comb begin
    addr = nb;
    wall_we = 1'b0; visit_we = 1'b0; parent_we = 1'b0; path_we = 1'b0;
    sq_we = 1'b0; tq_we = 1'b0;
    wall_wd = req.data.is_wall;
    path_wd = 1'b0;
    visit_wd = 2'd0;
    sq_addr = s_head[AW-1:0];
    tq_addr = t_head[AW-1:0];
    q_wd = nb;
    unique case (state)
      S_IDLE: begin
        addr = {req.data.cell_row, req.data.cell_col};
        wall_we = req.valid && req.ready && (req.data.action == gbb_pkg::ActWrite) &&
                  !frame(req.data.cell_row, req.data.cell_col);
      end
      S_WIPE: begin
        addr = wipe_cnt[AW-1:0];
        wall_we = init_pass && !wipe_cnt[AW];
        wall_wd = 1'b0;
        visit_we = !wipe_cnt[AW];
        path_we = !wipe_cnt[AW];
        // lay the seed marks down as the pass goes by
        if (!init_pass && si != ti) begin
          if (wipe_cnt[AW-1:0] == si) visit_wd = 2'd1;
          else if (wipe_cnt[AW-1:0] == ti) visit_wd = 2'd2;
        end
        if (wipe_cnt[AW] && !init_pass) begin
          // seed queues
          sq_we = 1'b1; sq_addr = '0; q_wd = si;
          tq_we = 1'b1; tq_addr = '0;
        end
      end
      S_DECIDE: begin
        addr = nb;
        if (new_visit && !hit_other) begin
          visit_we = 1'b1;
          visit_wd = side ? 2'd2 : 2'd1;
          parent_we = 1'b1;
          if (!side) begin
            sq_we = (s_tail < PW'(gbb_pkg::Cells)); sq_addr = s_tail[AW-1:0];
          end else begin
            tq_we = (t_tail < PW'(gbb_pkg::Cells)); tq_addr = t_tail[AW-1:0];
          end
        end
      end
      S_TRACE: begin
        addr = trace_idx;
        path_we = (trace_idx != trace_seed) && !trace_cnt[AW];
        path_wd = 1'b1;
      end
      default: addr = nb;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[addr] <= wall_wd;
    wall_rd <= wall_mem[addr];
    if (visit_we) visit_mem[addr] <= visit_wd;
    visit_rd <= visit_mem[addr];
    if (parent_we) parent_mem[addr] <= dir;
    parent_rd <= parent_mem[addr];
    if (path_we) path_mem[addr] <= path_wd;
    path_rd <= path_mem[addr];
    if (sq_we) sq_mem[sq_addr] <= q_wd;
    sq_rd <= sq_mem[sq_addr];
    if (tq_we) tq_mem[tq_addr] <= (state == S_WIPE) ? ti : q_wd;
    tq_rd <= tq_mem[tq_addr];
  end

  assign req.ready = (state == S_IDLE) && !rst;
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = out_q;

  logic [2:0] mark;
  always_comb begin
    if (rd_row == start_row && rd_col == start_col) mark = gbb_pkg::MarkStart;
    else if (rd_row == target_row && rd_col == target_col) mark = gbb_pkg::MarkTarget;
    else if (frame(rd_row, rd_col) || wall_rd) mark = gbb_pkg::MarkWall;
    else if (path_rd) mark = gbb_pkg::MarkPath;
    else if (visit_rd == 2'd1) mark = gbb_pkg::MarkSSide;
    else if (visit_rd == 2'd2) mark = gbb_pkg::MarkTSide;
    else mark = gbb_pkg::MarkOpen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      wipe_cnt <= '0;
      init_pass <= 1'b1;
      start_row <= CW'(64); start_col <= CW'(64);
      target_row <= CW'(1); target_col <= CW'(1);
      expansions_per_turn <= 5'd5;
      s_head <= '0; s_tail <= '0; t_head <= '0; t_tail <= '0;
      out_q <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gbb_pkg::RegStartRow:  start_row <= cfg_data;
          gbb_pkg::RegStartCol:  start_col <= cfg_data;
          gbb_pkg::RegTargetRow: target_row <= cfg_data;
          gbb_pkg::RegTargetCol: target_col <= cfg_data;
          gbb_pkg::RegExpand:    expansions_per_turn <= cfg_data[4:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (req.valid) begin
          out_q <= '0;
          rd_row <= req.data.cell_row;
          rd_col <= req.data.cell_col;
          unique case (req.data.action)
            gbb_pkg::ActWrite: state <= S_OUT;
            gbb_pkg::ActRead: state <= S_READ_WAIT;
            gbb_pkg::ActRun: begin
              s_head <= '0; s_tail <= '0; t_head <= '0; t_tail <= '0;
              wipe_cnt <= '0;
              state <= S_WIPE;
            end
            default: state <= S_OUT;
          endcase
        end
        S_READ_WAIT: begin
          out_q.cell_mark <= mark;
          state <= S_OUT;
        end
        S_WIPE: begin
          if (wipe_cnt[AW]) begin
            if (init_pass) begin
              init_pass <= 1'b0;
              state <= S_IDLE;
            end else if (si == ti) begin
              out_q <= {gbb_pkg::StFound, 3'd0, si};
              state <= S_OUT;
            end else begin
              s_tail <= PW'(1); t_tail <= PW'(1);
              side <= 1'b0;
              turn_cnt <= '0;
              state <= S_POP;
            end
          end else begin
            wipe_cnt <= wipe_cnt + 1'b1;
          end
        end
        S_POP: begin
          // pick a side: the turn passes when the count runs out or queue empties; both empty gives no path
          if (!s_has && !t_has) begin
            out_q.status <= gbb_pkg::StNoPath;
            state <= S_OUT;
          end else if (!side && (!s_has || turn_cnt >= per)) begin
            side <= 1'b1; turn_cnt <= '0;
          end else if (side && (!t_has || turn_cnt >= per)) begin
            side <= 1'b0; turn_cnt <= '0;
          end else begin
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          // queue read data is valid here, registered from the head address set in S_POP
          cur <= side ? tq_rd : sq_rd;
          if (side) t_head <= t_head + 1'b1; else s_head <= s_head + 1'b1;
          turn_cnt <= turn_cnt + 1'b1;
          dir <= 2'd0;
          state <= S_PROBE;
        end
        S_PROBE: begin
          nb <= {nr, nc};
          nb_ok <= nb_in && !frame(nr, nc);
          state <= S_PROBE_WAIT;
        end
        S_PROBE_WAIT: state <= S_DECIDE;
        S_DECIDE: begin
          if (hit_other) begin
            meet <= nb;
            trace_side <= side;
            trace_idx <= cur;
            trace_nb <= nb;
            trace_pass <= 1'b0;
            trace_cnt <= '0;
            state <= S_TRACE;
          end else begin
            if (new_visit) begin
              if (!side && s_tail < PW'(gbb_pkg::Cells)) s_tail <= s_tail + 1'b1;
              if (side && t_tail < PW'(gbb_pkg::Cells)) t_tail <= t_tail + 1'b1;
            end
            if (dir == 2'd3) state <= S_POP;
            else begin
              dir <= dir + 1'b1;
              state <= S_PROBE;
            end
          end
        end
        S_TRACE: begin
          if (trace_idx == trace_seed || trace_cnt[AW]) begin
            if (!trace_pass) begin
              trace_pass <= 1'b1;
              trace_side <= !trace_side;
              trace_idx <= trace_nb;
              trace_cnt <= '0;
            end else begin
              out_q <= {gbb_pkg::StFound, 3'd0, meet};
              state <= S_OUT;
            end
          end else begin
            state <= S_TRACE_WAIT;
          end
        end
        S_TRACE_WAIT: begin
          if (!p_in) begin
            trace_cnt <= {1'b1, {AW{1'b0}}};
          end else begin
            trace_cnt <= trace_cnt + 1'b1;
            trace_idx <= {pr, pc};
          end
          state <= S_TRACE;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    s_head <= s_tail && t_head <= t_tail)
    else $error("queue head passed tail");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result dropped");
  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("request taken while busy");
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  localparam int GS = gbb_pkg::GridSide;
  localparam int NC = gbb_pkg::Cells;
  localparam int CW = gbb_pkg::CoordW;
  localparam int DW = gbb_pkg::CfgDataW;

  class grid_scoreboard;
    gbb_pkg::rsp_t pending_q[$];
    int   errors;
    int   checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function void note_request(gbb_pkg::rsp_t e);
      pending_q.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(gbb_pkg::rsp_t got);
      gbb_pkg::rsp_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.cell_mark !== e.cell_mark)
        report($sformatf("cell_mark %0d, want %0d", got.cell_mark, e.cell_mark));
      if (got.meet_row !== e.meet_row || got.meet_col !== e.meet_col)
        report($sformatf("meet %0d,%0d, want %0d,%0d", got.meet_row, got.meet_col,
                         e.meet_row, e.meet_col));
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [gbb_pkg::CfgIdxW-1:0]  cfg_index;
  logic [gbb_pkg::CfgDataW-1:0] cfg_data;

  gbb_req_if req_ch ();
  gbb_rsp_if rsp_ch ();

  grid_bidirectional_bfs_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  grid_scoreboard sb = new();

  // idling mode: 0 none, 1 sender, 2 receiver, 3 both
  int mode;
  int n_runs, n_found, n_nopath;

  // predictor state
  bit        wall_m [NC];
  bit [1:0]  visit_m[NC];
  bit [1:0]  par_m  [NC];
  bit        path_m [NC];
  int        q_m    [2][NC];
  int        head_m [2];
  int        tail_m [2];
  int        meet_m;
  int        seed_m [2];
  bit [6:0]  c_sr, c_sc, c_tr, c_tc;
  bit [4:0]  c_exp;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int dr(int d);
    return d == 0 ? 1 : (d == 1 ? -1 : 0);
  endfunction

  function automatic int dc(int d);
    return d == 2 ? 1 : (d == 3 ? -1 : 0);
  endfunction

  function automatic bit on_frame(int r, int c);
    return r == 0 || c == 0 || r == GS - 1 || c == GS - 1;
  endfunction

  function automatic bit blocked_at(int r, int c);
    if (r < 0 || c < 0 || r >= GS || c >= GS) return 1'b1;
    return on_frame(r, c) || wall_m[r * GS + c];
  endfunction

  function automatic void mark_chain(int idx, int side);
    int n, d, r, c;
    n = 0;
    while (idx != seed_m[side - 1] && n < NC) begin
      path_m[idx] = 1'b1;
      d = par_m[idx];
      r = idx / GS - dr(d);
      c = idx % GS - dc(d);
      if (r < 0 || c < 0 || r >= GS || c >= GS) break;
      idx = r * GS + c;
      n++;
    end
  endfunction

  function automatic bit grow_side(int side);
    int s, cur, cr, cc, nr, nc, n;
    s = side - 1;
    if (head_m[s] >= tail_m[s]) return 1'b0;
    cur = q_m[s][head_m[s]];
    head_m[s]++;
    cr = cur / GS;
    cc = cur % GS;
    for (int d = 0; d < 4; d++) begin
      nr = cr + dr(d);
      nc = cc + dc(d);
      if (blocked_at(nr, nc)) continue;
      n = nr * GS + nc;
      if (visit_m[n] == 0) begin
        visit_m[n] = 2'(side);
        par_m[n]   = 2'(d);
        if (tail_m[s] < NC) begin
          q_m[s][tail_m[s]] = n;
          tail_m[s]++;
        end
      end else if (visit_m[n] == 3 - side) begin
        meet_m = n;
        mark_chain(cur, side);
        mark_chain(n, 3 - side);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] search_grid();
    int si, ti, per;
    bit found;
    for (int i = 0; i < NC; i++) begin
      visit_m[i] = 0;
      path_m[i]  = 0;
    end
    head_m = '{0, 0};
    tail_m = '{0, 0};
    meet_m = 0;
    si = c_sr * GS + c_sc;
    ti = c_tr * GS + c_tc;
    seed_m = '{si, ti};
    if (si == ti) begin
      meet_m = si;
      return gbb_pkg::StFound;
    end
    visit_m[si] = 1;
    q_m[0][0] = si;
    tail_m[0] = 1;
    visit_m[ti] = 2;
    q_m[1][0] = ti;
    tail_m[1] = 1;
    per = c_exp == 0 ? 1 : c_exp;
    found = 1'b0;
    while (!found && (head_m[0] < tail_m[0] || head_m[1] < tail_m[1])) begin
      for (int k = 0; k < per && head_m[0] < tail_m[0] && !found; k++)
        found = grow_side(1);
      for (int k = 0; k < per && head_m[1] < tail_m[1] && !found; k++)
        found = grow_side(2);
    end
    return found ? gbb_pkg::StFound : gbb_pkg::StNoPath;
  endfunction

  function automatic logic [2:0] mark_at(int r, int c);
    int idx;
    if (r == c_sr && c == c_sc) return gbb_pkg::MarkStart;
    if (r == c_tr && c == c_tc) return gbb_pkg::MarkTarget;
    if (blocked_at(r, c)) return gbb_pkg::MarkWall;
    idx = r * GS + c;
    if (path_m[idx]) return gbb_pkg::MarkPath;
    if (visit_m[idx] == 1) return gbb_pkg::MarkSSide;
    if (visit_m[idx] == 2) return gbb_pkg::MarkTSide;
    return gbb_pkg::MarkOpen;
  endfunction

  function automatic gbb_pkg::rsp_t predict_grid(gbb_pkg::req_t x);
    gbb_pkg::rsp_t e;
    e = '0;
    case (x.action)
      gbb_pkg::ActWrite: begin
        if (!on_frame(x.cell_row, x.cell_col))
          wall_m[x.cell_row * GS + x.cell_col] = x.is_wall;
      end
      gbb_pkg::ActRun: begin
        e.status = search_grid();
        n_runs++;
        if (e.status == gbb_pkg::StFound) begin
          n_found++;
          e.meet_row = CW'(meet_m / GS);
          e.meet_col = CW'(meet_m % GS);
        end else begin
          n_nopath++;
        end
      end
      gbb_pkg::ActRead: e.cell_mark = mark_at(x.cell_row, x.cell_col);
      default: ;
    endcase
    return e;
  endfunction

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request(predict_grid(req_ch.data));
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.data);
  end

  always @(posedge clk) begin
    if (mode == 3)
      rsp_ch.ready <= ($urandom % 100) >= 29;
    else if (mode == 2)
      rsp_ch.ready <= ($urandom % 100) >= 77;
    else
      rsp_ch.ready <= 1'b1;
  end

  task automatic send(bit [1:0] act, int r, int c, bit w);
    gbb_pkg::req_t x;
    int idle_pct;
    x.action   = act;
    x.cell_row = CW'(r);
    x.cell_col = CW'(c);
    x.is_wall  = w;
    idle_pct = (mode == 3) ? 29 : 77;
    if ((mode == 1 || mode == 3) && ($urandom % 100) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= x;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic set_reg(logic [gbb_pkg::CfgIdxW-1:0] idx, int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DW'(v);
    case (idx)
      gbb_pkg::RegStartRow:  c_sr  = 7'(v);
      gbb_pkg::RegStartCol:  c_sc  = 7'(v);
      gbb_pkg::RegTargetRow: c_tr  = 7'(v);
      gbb_pkg::RegTargetCol: c_tc  = 7'(v);
      gbb_pkg::RegExpand:    c_exp = 5'(v);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_seeds(int sr, int sc, int tr, int tc, int ex);
    drain();
    set_reg(gbb_pkg::RegStartRow, sr);
    set_reg(gbb_pkg::RegStartCol, sc);
    set_reg(gbb_pkg::RegTargetRow, tr);
    set_reg(gbb_pkg::RegTargetCol, tc);
    set_reg(gbb_pkg::RegExpand, ex);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_coord();
    return ($urandom % 10 == 0) ? $urandom_range(0, 127) : $urandom_range(0, 25);
  endfunction

  function automatic int pick_expand();
    case ($urandom % 6)
      0: return 0;
      1: return 1;
      2: return 16;
      3: return 31;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  initial begin
    int total;
    mode = 0;
    n_runs = 0;
    n_found = 0;
    n_nopath = 0;
    c_sr = 64; c_sc = 64; c_tr = 1; c_tc = 1; c_exp = 5;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: marks after reset, frame and unknown requests, default seeds
    send(gbb_pkg::ActRead, 64, 64, 0);
    send(gbb_pkg::ActRead, 1, 1, 0);
    send(gbb_pkg::ActRead, 0, 5, 0);
    send(gbb_pkg::ActRead, 127, 127, 1);
    send(gbb_pkg::ActWrite, 0, 3, 1);
    send(gbb_pkg::ActWrite, 127, 10, 1);
    send(gbb_pkg::ActRead, 0, 3, 0);
    send(gbb_pkg::ActRead, 2, 2, 0);
    send(gbb_pkg::ActSpare, 127, 127, 1);
    send(gbb_pkg::ActRun, 0, 0, 0);
    send(gbb_pkg::ActRead, 64, 1, 0);
    send(gbb_pkg::ActRead, 2, 1, 0);
    // far corners, turn of 16 expansions
    set_seeds(126, 126, 1, 1, 16);
    send(gbb_pkg::ActRun, 0, 0, 0);
    send(gbb_pkg::ActRead, 126, 125, 0);
    // same seed
    set_seeds(5, 5, 5, 5, 1);
    send(gbb_pkg::ActRun, 0, 0, 0);
    // seed on the frame, zero expansions
    set_seeds(0, 5, 3, 5, 0);
    send(gbb_pkg::ActRun, 0, 0, 0);
    send(gbb_pkg::ActRead, 1, 5, 0);
    // start seed boxed in, wall on the target cell: no path
    set_seeds(10, 10, 20, 20, 31);
    send(gbb_pkg::ActWrite, 9, 10, 1);
    send(gbb_pkg::ActWrite, 11, 10, 1);
    send(gbb_pkg::ActWrite, 10, 9, 1);
    send(gbb_pkg::ActWrite, 10, 11, 1);
    send(gbb_pkg::ActWrite, 20, 20, 1);
    send(gbb_pkg::ActRun, 0, 0, 0);
    send(gbb_pkg::ActRead, 10, 10, 0);

    // random: wall, read and spare traffic mostly in a corner region, a run every fiftieth request
    total = 1950;
    for (int i = 0; i < total; i++) begin
      mode = (i * 4) / total;
      if (i % 50 == 49) begin
        if ($urandom % 2)
          set_seeds($urandom_range(1, 24), $urandom_range(1, 24),
                    $urandom_range(1, 24), $urandom_range(1, 24), pick_expand());
        send(gbb_pkg::ActRun, pick_coord(), pick_coord(), $urandom % 2);
      end else begin
        case ($urandom % 50)
          0: send(gbb_pkg::ActSpare, pick_coord(), pick_coord(), $urandom % 2);
          1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22:
            send(gbb_pkg::ActWrite, pick_coord(), pick_coord(), ($urandom % 4) == 0);
          default: send(gbb_pkg::ActRead, pick_coord(), pick_coord(), $urandom % 2);
        endcase
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

    $display("checked %0d results over %0d searches (%0d found, %0d without path)",
             sb.checked, n_runs, n_found, n_nopath);
    if (sb.errors == 0)
      $display("grid_bidirectional_bfs_core regression: pass");
    else
      $display("grid_bidirectional_bfs_core regression: fail");
    $finish;
  end

  initial begin
    #(64'd600_000_000);
    $display("grid_bidirectional_bfs_core regression: fail");
    $finish;
  end
endmodule

### grid_bidirectional_bfs_core.f
src/gbb_pkg.sv
src/gbb_req_if.sv
src/gbb_rsp_if.sv
src/grid_bidirectional_bfs_core.sv
bench/tb_top.sv
